[design/lzssd_pkg.sv]
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Shared constants for the LZSS byte decompressor and its history RAM.
// ----------------------------------------------------------------------------
`default_nettype none

package lzssd_pkg;

  // Width of one stream byte.
  localparam int unsigned BYTE_W = 8;

  // Default size of the history window.
  localparam int unsigned WINDOW_BYTES_DEF = 4096;

  // Width of the length nibble of a match.
  localparam int unsigned LEN_W = 4;

  // The write position starts this many bytes before the window wraps.
  localparam int unsigned START_BACKOFF = 18;

endpackage : lzssd_pkg

`default_nettype wire

[design/lzssd_history.sv]
// ----------------------------------------------------------------------------
// LZSS history RAM
// Single write port and single read port; the read data is registered and
// holds its value between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module lzssd_history #(
  parameter int unsigned WINDOW_BYTES = lzssd_pkg::WINDOW_BYTES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              wr_en_i,
  input  wire logic [$clog2(WINDOW_BYTES)-1:0]   wr_addr_i,
  input  wire logic [lzssd_pkg::BYTE_W-1:0]      wr_data_i,
  input  wire logic                              rd_en_i,
  input  wire logic [$clog2(WINDOW_BYTES)-1:0]   rd_addr_i,
  output logic      [lzssd_pkg::BYTE_W-1:0]      rd_data_o
);
  import lzssd_pkg::*;

  logic [BYTE_W-1:0] mem_q [WINDOW_BYTES];
  logic [BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule : lzssd_history

`default_nettype wire

[design/lzss_byte_decompressor.sv]
// ----------------------------------------------------------------------------
// LZSS byte decompressor
// Decodes an LZSS stream with a 4 KB history window, one compressed byte per
// input transfer, and emits the decompressed bytes one per output transfer.
// ----------------------------------------------------------------------------
// A flag byte, a literal byte or the low byte of a match is taken from the
// input; a literal leaves one output byte through the output register, and
// the next input is taken only once that byte can leave, in the same cycle at
// the earliest. After the high byte of a match is taken, the block copies 3
// to 18 bytes, each with a read state and then a write-back state (which waits
// while the output side stalls), and accepts no input until the copy is done.
// Each copied byte is written back before the next one is read, and the
// history RAM read is registered, so the read and write-back of a byte are
// separate states. After reset, and after each input transfer marked with
// tlast (for a match high byte once its copy is done), the block zeroes all
// WINDOW_BYTES entries of the history RAM in a pass, one entry per cycle,
// during which no input is accepted. s_axis_tlast_i marks the final byte of a
// stream; m_axis_tlast_o marks the last output byte caused by one input byte.
`default_nettype none

module lzss_byte_decompressor #(
  parameter int unsigned WINDOW_BYTES = lzssd_pkg::WINDOW_BYTES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [lzssd_pkg::BYTE_W-1:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic                          s_axis_tlast_i,   // is_last
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic      [lzssd_pkg::BYTE_W-1:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic                               m_axis_tlast_o    // last_of_run
);
  import lzssd_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_BYTES);
  // The copy counter holds length - 1, up to 17, so it needs one bit more
  // than the length nibble.
  localparam int unsigned CNT_W = LEN_W + 1;
  localparam logic [AW-1:0] START_POS = AW'(WINDOW_BYTES - START_BACKOFF);
  localparam logic [AW-1:0] CLEAR_LAST = AW'(WINDOW_BYTES - START_BACKOFF - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR
  } state_e;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_DATA,
    PH_HIGH
  } phase_e;

  state_e              state_q, state_d;
  phase_e              phase_q, phase_d;
  logic [AW-1:0]       wp_q, wp_d;
  logic [AW-1:0]       src_q, src_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [BYTE_W-1:0]   flags_q, flags_d;
  logic [3:0]          left_q, left_d;
  logic [BYTE_W-1:0]   pend_q, pend_d;
  logic                end_q, end_d;
  logic                out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]   out_data_q, out_data_d;
  logic                out_last_q, out_last_d;

  logic                s_fire;
  logic                out_free;
  logic                out_load;
  logic [3:0]          left_dec;
  logic [AW-1:0]       wp_inc;

  logic                mem_wr_en;
  logic [AW-1:0]       mem_wr_addr;
  logic [BYTE_W-1:0]   mem_wr_data;
  logic                mem_rd_en;
  logic [BYTE_W-1:0]   mem_rd_data;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign left_dec        = left_q - 4'd1;
  assign wp_inc          = wp_q + AW'(1);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    wp_d        = wp_q;
    src_d       = src_q;
    cnt_d       = cnt_q;
    flags_d     = flags_q;
    left_d      = left_q;
    pend_d      = pend_q;
    end_d       = end_q;
    out_load    = 1'b0;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    mem_wr_en   = 1'b0;
    mem_wr_addr = wp_q;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // Zero one entry per cycle until the position comes back to the start.
        mem_wr_en = 1'b1;
        wp_d      = wp_inc;
        if (wp_q == CLEAR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_fire) begin
          unique case (phase_q)
            PH_DATA: begin
              flags_d = flags_q >> 1;
              left_d  = left_dec;
              if (flags_q[0]) begin
                out_load    = 1'b1;
                out_data_d  = s_axis_tdata_i;
                out_last_d  = 1'b1;
                mem_wr_en   = 1'b1;
                mem_wr_data = s_axis_tdata_i;
                wp_d        = wp_inc;
                phase_d     = (left_dec == 4'd0) ? PH_FLAG : PH_DATA;
              end else begin
                pend_d  = s_axis_tdata_i;
                phase_d = PH_HIGH;
              end
            end
            PH_HIGH: begin
              src_d   = AW'({s_axis_tdata_i[7:4], pend_q});
              cnt_d   = {1'b0, s_axis_tdata_i[LEN_W-1:0]} + CNT_W'(2);
              end_d   = s_axis_tlast_i;
              phase_d = (left_q == 4'd0) ? PH_FLAG : PH_DATA;
              state_d = ST_COPY_RD;
            end
            default: begin
              flags_d = s_axis_tdata_i;
              left_d  = 4'd8;
              phase_d = PH_DATA;
            end
          endcase
          // A match high byte finishes its copy before the end of stream.
          if (s_axis_tlast_i && phase_q != PH_HIGH) begin
            state_d = ST_CLEAR;
          end
        end
      end
      ST_COPY_RD: begin
        mem_rd_en = 1'b1;
        state_d   = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        // Writing back before the next read keeps overlapping copies exact.
        if (out_free) begin
          out_load    = 1'b1;
          out_data_d  = mem_rd_data;
          out_last_d  = (cnt_q == '0);
          mem_wr_en   = 1'b1;
          mem_wr_data = mem_rd_data;
          wp_d        = wp_inc;
          src_d       = src_q + AW'(1);
          cnt_d       = cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            state_d = end_q ? ST_CLEAR : ST_IDLE;
          end else begin
            state_d = ST_COPY_RD;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase

    // Entering the clearing pass returns all parse state to its start.
    if (state_d == ST_CLEAR && state_q != ST_CLEAR) begin
      wp_d    = START_POS;
      phase_d = PH_FLAG;
      flags_d = '0;
      left_d  = 4'd0;
      pend_d  = '0;
      end_d   = 1'b0;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      phase_q     <= PH_FLAG;
      wp_q        <= START_POS;
      src_q       <= '0;
      cnt_q       <= '0;
      flags_q     <= '0;
      left_q      <= 4'd0;
      pend_q      <= '0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      wp_q        <= wp_d;
      src_q       <= src_d;
      cnt_q       <= cnt_d;
      flags_q     <= flags_d;
      left_q      <= left_d;
      pend_q      <= pend_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  lzssd_history #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_history (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (src_q),
    .rd_data_o (mem_rd_data)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // The end of a stream always leads into the clearing pass or a final copy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast_i |=> state_q == ST_CLEAR || state_q == ST_COPY_RD)
    else $error("end of stream did not start the clearing pass");

  // No output byte is produced while the history is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !out_load)
    else $error("output produced during clearing pass");

  // A copied byte that can leave always lands in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COPY_WR && out_free |=> m_axis_tvalid_o)
    else $error("copied byte lost");

  // A flag byte arms eight decisions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && phase_q == PH_FLAG && !s_axis_tlast_i |=> phase_q == PH_DATA && left_q == 4'd8)
    else $error("flag byte not loaded");

  // Only the final byte of a match carries the run marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COPY_WR && out_free && cnt_q != '0 |=> !m_axis_tlast_o)
    else $error("run marker on an inner copied byte");

endmodule : lzss_byte_decompressor

`default_nettype wire
